[sv/btc_pkg.sv]
package btc_pkg;

    // Angles are in 1/65536 degree; one full turn is 360 degrees.
    localparam int FULL_TURN          = 23592960;
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);
    localparam int QUARTER_IDX        = SINE_TABLE_ENTRIES / 4;
    localparam int SINE_W             = 18;

    // One table step is FULL_TURN / entries = 45 * 2^STEP_SHIFT angle units.
    localparam int TURN_STEP   = FULL_TURN / SINE_TABLE_ENTRIES;
    localparam int STEP_ODD    = 45;
    localparam int STEP_SHIFT  = $clog2(TURN_STEP / STEP_ODD);
    localparam int TURN_Q_W    = 32 - STEP_SHIFT;
    // Bias by a whole number of turns so the dividend is never negative.
    localparam int BIAS_TURNS  = (2 ** (TURN_Q_W - 1)) / (STEP_ODD * SINE_TABLE_ENTRIES) + 1;
    localparam int TURN_BIAS   = STEP_ODD * SINE_TABLE_ENTRIES * BIAS_TURNS;
    localparam int TURN_U_W    = TURN_Q_W + 1;
    // Divide by STEP_ODD through a rounded-up reciprocal.
    localparam int RECIP_SHIFT = TURN_U_W + 6;
    localparam int RECIP_W     = TURN_U_W + 1;
    localparam logic [63:0] RECIP_MUL = ((64'd1 << RECIP_SHIFT) / 64'(STEP_ODD)) + 64'd1;
    localparam int TURN_PROD_W = TURN_U_W + RECIP_W;

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SINE_W-1:0] sine_val_t;
    typedef sine_val_t sine_rom_t [SINE_TABLE_ENTRIES];

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic        [16:0] alpha;
    } side_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } pos_t;

    // Sine of f quarter turns, f in Q30 over [0, 1], by a Horner series; Q30 result.
    // The series divisors are (2n)(2n+1) for n from 8 down to 1.
    function automatic logic [63:0] sin_quarter(input logic [63:0] f);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        x = (f * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        h = ONE_Q30;
        h = ONE_Q30 - (((x2 * h) >> 30) / 64'd272);
        h = ONE_Q30 - (((x2 * h) >> 30) / 64'd210);
        h = ONE_Q30 - (((x2 * h) >> 30) / 64'd156);
        h = ONE_Q30 - (((x2 * h) >> 30) / 64'd110);
        h = ONE_Q30 - (((x2 * h) >> 30) / 64'd72);
        h = ONE_Q30 - (((x2 * h) >> 30) / 64'd42);
        h = ONE_Q30 - (((x2 * h) >> 30) / 64'd20);
        h = ONE_Q30 - (((x2 * h) >> 30) / 64'd6);
        return (x * h) >> 30;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] f;
        logic [63:0] m;
        for (int k = 0; k < SINE_TABLE_ENTRIES; k++)
        begin
            p = (64'(k) << 32) / 64'(SINE_TABLE_ENTRIES);
            q = (p >> 30) & 64'd3;
            f = p & (ONE_Q30 - 64'd1);
            if (q[0])
            begin
                f = ONE_Q30 - f;
            end
            m = (sin_quarter(f) + 64'd8192) >> 14;
            rom[k] = (q >= 64'd2) ? -sine_val_t'(m) : sine_val_t'(m);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [48:0] hi;
        logic signed [48:0] lo;
        hi = 49'sd2147483647;
        lo = -49'sd2147483648;
        if (v > hi)
        begin
            return 32'sh7fffffff;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

[sv/bone_transform_compose.sv]
// Channel   Handshake           Transfer at rising edge    Payload
// --------  ------------------  -------------------------  ------------------------------
// input     start / busy        start && !busy             child_*, parent_* (12 fields)
// result    done (strobe)       every edge with done high  world_* (6 fields)
//
// One item is taken every cycle. The path through the sine table, then the
// 48x18 rotation multiplies cut into partial products, sets the depth.
// busy is never raised: the pipeline has no back pressure, and the receiver
// cannot stall, so every result is shown for exactly one cycle.
// Reset clears the valid bits only; data registers hold whatever they last had.
module bone_transform_compose
    import btc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] child_x,
    input  logic signed [31:0] child_y,
    input  logic signed [31:0] child_angle,
    input  logic signed [31:0] child_scale_x,
    input  logic signed [31:0] child_scale_y,
    input  logic        [16:0] child_alpha,
    input  logic signed [31:0] parent_x,
    input  logic signed [31:0] parent_y,
    input  logic signed [31:0] parent_angle,
    input  logic signed [31:0] parent_scale_x,
    input  logic signed [31:0] parent_scale_y,
    input  logic        [16:0] parent_alpha,
    output logic               done,
    output logic signed [31:0] world_x,
    output logic signed [31:0] world_y,
    output logic signed [31:0] world_angle,
    output logic signed [31:0] world_scale_x,
    output logic signed [31:0] world_scale_y,
    output logic        [16:0] world_alpha
);

    localparam int STAGES = 7;
    localparam int MX_W   = 48;
    localparam int HALF_W = 24;
    localparam int HI_W   = MX_W - HALF_W + SINE_W;
    localparam int LO_W   = HALF_W + 1 + SINE_W;

    // Rotation terms: offset component times sine or cosine.
    localparam logic [1:0] TERM_MXC = 2'd0;
    localparam logic [1:0] TERM_MYS = 2'd1;
    localparam logic [1:0] TERM_MXS = 2'd2;
    localparam logic [1:0] TERM_MYC = 2'd3;

    localparam logic signed [33:0] TURN_34 = 34'(FULL_TURN);
    localparam logic [TURN_U_W-1:0] BIAS_U = TURN_U_W'(TURN_BIAS);
    localparam logic [RECIP_W-1:0]  RECIP_U = RECIP_MUL[RECIP_W-1:0];

    logic accept;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    // Stage 1: products, angle sum, turn dividend
    logic signed [63:0] s1_mx_prod_reg, s1_mx_prod_next;
    logic signed [63:0] s1_my_prod_reg, s1_my_prod_next;
    logic signed [63:0] s1_sx_prod_reg, s1_sx_prod_next;
    logic signed [63:0] s1_sy_prod_reg, s1_sy_prod_next;
    logic        [33:0] s1_al_prod_reg, s1_al_prod_next;
    logic signed [33:0] s1_ang_sum_reg, s1_ang_sum_next;
    logic [TURN_U_W-1:0] s1_turn_u_reg, s1_turn_u_next;
    logic signed [32:0] ang_term;
    logic signed [31:0] turn_shift;

    // Stage 2: rounded offsets, table index product, finished side results
    logic signed [MX_W-1:0] s2_mx_reg, s2_mx_next;
    logic signed [MX_W-1:0] s2_my_reg, s2_my_next;
    logic [TURN_PROD_W-1:0] s2_turn_prod_reg, s2_turn_prod_next;
    side_t side_next;
    logic signed [63:0] sx_round;
    logic signed [63:0] sy_round;
    logic signed [63:0] mx_round;
    logic signed [63:0] my_round;
    logic signed [33:0] ang_wrap;
    logic        [34:0] al_round;

    // Stage 3: sine and cosine
    logic signed [MX_W-1:0] s3_mx_reg;
    logic signed [MX_W-1:0] s3_my_reg;
    sine_val_t s3_sin_reg, s3_sin_next;
    sine_val_t s3_cos_reg, s3_cos_next;
    logic [SINE_IDX_W-1:0] sin_idx;
    logic [SINE_IDX_W-1:0] cos_idx;

    // Stage 4 to 6: rotation arithmetic
    logic signed [HI_W-1:0] s4_hi_reg [4];
    logic signed [HI_W-1:0] s4_hi_next [4];
    logic signed [LO_W-1:0] s4_lo_reg [4];
    logic signed [LO_W-1:0] s4_lo_next [4];
    logic signed [HALF_W-1:0] mx_hi;
    logic signed [HALF_W-1:0] my_hi;
    logic signed [HALF_W:0]   mx_lo;
    logic signed [HALF_W:0]   my_lo;
    logic signed [63:0] s5_full_reg [4];
    logic signed [63:0] s5_full_next [4];
    logic signed [63:0] s6_acc_x_reg, s6_acc_x_next;
    logic signed [63:0] s6_acc_y_reg, s6_acc_y_next;

    // Stage 7: output registers
    logic signed [31:0] world_x_reg, world_x_next;
    logic signed [31:0] world_y_reg, world_y_next;

    // Side results and parent position travel alongside the rotation path
    side_t side_reg [2:STAGES];
    pos_t  pos_reg  [1:STAGES-1];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign valid_next = {valid_reg[STAGES-2:0], accept};

    // Stage 1
    always_comb
    begin
        s1_mx_prod_next = child_x * parent_scale_x;
        s1_my_prod_next = child_y * parent_scale_y;
        s1_sx_prod_next = child_scale_x * parent_scale_x;
        s1_sy_prod_next = child_scale_y * parent_scale_y;
        s1_al_prod_next = 34'(child_alpha) * 34'(parent_alpha);
        // Mirror the child angle when exactly one parent scale is negative; drop it on zero.
        if (parent_scale_x == 32'sd0 || parent_scale_y == 32'sd0)
        begin
            ang_term = 33'sd0;
        end
        else if (parent_scale_x[31] == parent_scale_y[31])
        begin
            ang_term = {child_angle[31], child_angle};
        end
        else
        begin
            ang_term = -{child_angle[31], child_angle};
        end
        s1_ang_sum_next = {{2{parent_angle[31]}}, parent_angle} + {ang_term[32], ang_term};
        turn_shift = parent_angle >>> STEP_SHIFT;
        s1_turn_u_next = {turn_shift[TURN_Q_W-1], turn_shift[TURN_Q_W-1:0]} + BIAS_U;
    end

    // Stage 2
    always_comb
    begin
        mx_round = s1_mx_prod_reg + 64'sd32768;
        my_round = s1_my_prod_reg + 64'sd32768;
        s2_mx_next = mx_round[63:16];
        s2_my_next = my_round[63:16];
        s2_turn_prod_next = TURN_PROD_W'(s1_turn_u_reg) * TURN_PROD_W'(RECIP_U);

        // Subtract one turn once, no further folding.
        if (s1_ang_sum_reg >= TURN_34)
        begin
            ang_wrap = s1_ang_sum_reg - TURN_34;
        end
        else
        begin
            ang_wrap = s1_ang_sum_reg;
        end
        side_next.angle = sat32({{15{ang_wrap[33]}}, ang_wrap});

        sx_round = s1_sx_prod_reg + 64'sd32768;
        sy_round = s1_sy_prod_reg + 64'sd32768;
        side_next.scale_x = sat32({sx_round[63], sx_round[63:16]});
        side_next.scale_y = sat32({sy_round[63], sy_round[63:16]});

        al_round = {1'b0, s1_al_prod_reg} + 35'd32768;
        if (al_round[34:16] > 19'd65536)
        begin
            side_next.alpha = 17'd65536;
        end
        else
        begin
            side_next.alpha = al_round[32:16];
        end
    end

    // Stage 3: quotient by 45 modulo the table size gives the sine index
    always_comb
    begin
        sin_idx = s2_turn_prod_reg[RECIP_SHIFT +: SINE_IDX_W];
        cos_idx = sin_idx + SINE_IDX_W'(QUARTER_IDX);
        s3_sin_next = SINE_ROM[sin_idx];
        s3_cos_next = SINE_ROM[cos_idx];
    end

    // Stage 4: split each offset into a signed high and an unsigned low half
    always_comb
    begin
        mx_hi = s3_mx_reg[MX_W-1:HALF_W];
        my_hi = s3_my_reg[MX_W-1:HALF_W];
        mx_lo = {1'b0, s3_mx_reg[HALF_W-1:0]};
        my_lo = {1'b0, s3_my_reg[HALF_W-1:0]};
        s4_hi_next[TERM_MXC] = mx_hi * s3_cos_reg;
        s4_hi_next[TERM_MYS] = my_hi * s3_sin_reg;
        s4_hi_next[TERM_MXS] = mx_hi * s3_sin_reg;
        s4_hi_next[TERM_MYC] = my_hi * s3_cos_reg;
        s4_lo_next[TERM_MXC] = mx_lo * s3_cos_reg;
        s4_lo_next[TERM_MYS] = my_lo * s3_sin_reg;
        s4_lo_next[TERM_MXS] = mx_lo * s3_sin_reg;
        s4_lo_next[TERM_MYC] = my_lo * s3_cos_reg;
    end

    // Stage 5: recombine halves; every full term fits in 64 bits
    always_comb
    begin
        for (int t = 0; t < 4; t++)
        begin
            s5_full_next[t] = $signed({s4_hi_reg[t][63-HALF_W:0], {HALF_W{1'b0}}})
                            + $signed({{(64-LO_W){s4_lo_reg[t][LO_W-1]}}, s4_lo_reg[t]});
        end
    end

    // Stage 6: rotate, with the rounding constant folded in
    always_comb
    begin
        s6_acc_x_next = s5_full_reg[TERM_MXC] - s5_full_reg[TERM_MYS] + 64'sd32768;
        s6_acc_y_next = s5_full_reg[TERM_MXS] + s5_full_reg[TERM_MYC] + 64'sd32768;
    end

    // Stage 7: add the parent position and clamp
    always_comb
    begin
        world_x_next = sat32({s6_acc_x_reg[63], s6_acc_x_reg[63:16]}
                           + {{17{pos_reg[STAGES-1].x[31]}}, pos_reg[STAGES-1].x});
        world_y_next = sat32({s6_acc_y_reg[63], s6_acc_y_reg[63:16]}
                           + {{17{pos_reg[STAGES-1].y[31]}}, pos_reg[STAGES-1].y});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Data path: advance every cycle, the valid bits mark live items
    always_ff @(posedge clk)
    begin
        s1_mx_prod_reg   <= s1_mx_prod_next;
        s1_my_prod_reg   <= s1_my_prod_next;
        s1_sx_prod_reg   <= s1_sx_prod_next;
        s1_sy_prod_reg   <= s1_sy_prod_next;
        s1_al_prod_reg   <= s1_al_prod_next;
        s1_ang_sum_reg   <= s1_ang_sum_next;
        s1_turn_u_reg    <= s1_turn_u_next;
        pos_reg[1].x     <= parent_x;
        pos_reg[1].y     <= parent_y;

        s2_mx_reg        <= s2_mx_next;
        s2_my_reg        <= s2_my_next;
        s2_turn_prod_reg <= s2_turn_prod_next;
        side_reg[2]      <= side_next;

        s3_mx_reg        <= s2_mx_reg;
        s3_my_reg        <= s2_my_reg;
        s3_sin_reg       <= s3_sin_next;
        s3_cos_reg       <= s3_cos_next;

        for (int t = 0; t < 4; t++)
        begin
            s4_hi_reg[t]   <= s4_hi_next[t];
            s4_lo_reg[t]   <= s4_lo_next[t];
            s5_full_reg[t] <= s5_full_next[t];
        end

        s6_acc_x_reg     <= s6_acc_x_next;
        s6_acc_y_reg     <= s6_acc_y_next;

        world_x_reg      <= world_x_next;
        world_y_reg      <= world_y_next;

        for (int k = 2; k < STAGES; k++)
        begin
            pos_reg[k] <= pos_reg[k-1];
        end
        for (int k = 3; k <= STAGES; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign done          = valid_reg[STAGES-1];
    assign world_x       = world_x_reg;
    assign world_y       = world_y_reg;
    assign world_angle   = side_reg[STAGES].angle;
    assign world_scale_x = side_reg[STAGES].scale_x;
    assign world_scale_y = side_reg[STAGES].scale_y;
    assign world_alpha   = side_reg[STAGES].alpha;

`ifndef SYNTHESIS
    // Every result strobe traces back to an input transfer a fixed latency earlier.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, STAGES))
        else $error("result strobe without a matching input transfer");

    // Every input transfer yields a result after the pipeline latency.
    a_transfer_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("input transfer lost in the pipeline");

    // Opacity product is clamped to one.
    a_alpha_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (world_alpha <= 17'd65536))
        else $error("world_alpha above one");
`endif

endmodule

[tb/bone_transform_compose_test.sv]
`timescale 1ns / 100ps

module bone_transform_compose_test;
    import btc_pkg::*;

    // Fixed-point units: Q16.16 for positions and scales, 1/65536 degree for angles.
    localparam int Q_ONE          = 65536;
    localparam int DEG            = 65536;
    localparam int S_MAX          = 32'sh7fff_ffff;
    localparam int S_MIN          = 32'sh8000_0000;
    localparam int QUARTER_TURN   = FULL_TURN / 4;
    localparam int TABLE_STEP     = FULL_TURN / SINE_TABLE_ENTRIES;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTS    = 20;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    // Wide enough for every intermediate product without overflow.
    typedef logic signed [79:0] wide_t;

    typedef struct packed {
        logic signed [31:0] child_x;
        logic signed [31:0] child_y;
        logic signed [31:0] child_angle;
        logic signed [31:0] child_scale_x;
        logic signed [31:0] child_scale_y;
        logic        [16:0] child_alpha;
        logic signed [31:0] parent_x;
        logic signed [31:0] parent_y;
        logic signed [31:0] parent_angle;
        logic signed [31:0] parent_scale_x;
        logic signed [31:0] parent_scale_y;
        logic        [16:0] parent_alpha;
    } bone_pose_t;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_angle;
        logic signed [31:0] world_scale_x;
        logic signed [31:0] world_scale_y;
        logic        [16:0] world_alpha;
    } world_pose_t;

    // One row of the directed table: a pose, and a world pose typed in by hand
    // where it is obvious; otherwise the predictor supplies the expectation.
    typedef struct packed {
        bone_pose_t  pose;
        logic        pinned;
        world_pose_t want;
    } directed_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] child_x;
    logic signed [31:0] child_y;
    logic signed [31:0] child_angle;
    logic signed [31:0] child_scale_x;
    logic signed [31:0] child_scale_y;
    logic        [16:0] child_alpha;
    logic signed [31:0] parent_x;
    logic signed [31:0] parent_y;
    logic signed [31:0] parent_angle;
    logic signed [31:0] parent_scale_x;
    logic signed [31:0] parent_scale_y;
    logic        [16:0] parent_alpha;
    logic               done;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_angle;
    logic signed [31:0] world_scale_x;
    logic signed [31:0] world_scale_y;
    logic        [16:0] world_alpha;

    int            sine_lut [SINE_TABLE_ENTRIES];
    world_pose_t   world_due_q [$];
    directed_row_t directed_rows [$];
    int            burst_left        = 0;
    int            items_sent        = 0;
    int            zero_offset_items = 0;
    int            results_checked   = 0;
    int            mismatches        = 0;
    int            stall_cycles      = 0;

    bone_transform_compose dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Sine of f quarter turns (f in Q30 over [0, 1]) by a Horner series; Q30 out.
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] f);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] d;
        x  = (f * Q30_HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        h  = Q30_ONE;
        for (int n = 8; n >= 1; n--)
        begin
            d = 64'(2 * n) * 64'(2 * n + 1);
            h = Q30_ONE - (((x2 * h) >> 30) / d);
        end
        return (x * h) >> 30;
    endfunction

    // Build the Q1.16 sine table: fold each phase into the first quadrant,
    // evaluate, round 30 fractional bits to 16, and restore the sign.
    function automatic void fill_sine_lut();
        logic [63:0] phase;
        logic [63:0] quadrant;
        logic [63:0] frac;
        logic [63:0] mag;
        for (int k = 0; k < SINE_TABLE_ENTRIES; k++)
        begin
            phase    = (64'(k) << 32) / SINE_TABLE_ENTRIES;
            quadrant = (phase >> 30) & 64'd3;
            frac     = phase & (Q30_ONE - 64'd1);
            if (quadrant[0])
            begin
                frac = Q30_ONE - frac;
            end
            mag = (quarter_sine_q30(frac) + 64'd8192) >> 14;
            sine_lut[k] = quadrant[1] ? -int'(mag) : int'(mag);
        end
    endfunction

    // Table lookup after reduction to a non-negative angle below one turn.
    function automatic wide_t lut_sine(input wide_t ang);
        wide_t r;
        wide_t idx;
        r = ang % FULL_TURN;
        if (r < 0)
        begin
            r = r + FULL_TURN;
        end
        idx = (r * SINE_TABLE_ENTRIES) / FULL_TURN;
        if (idx >= SINE_TABLE_ENTRIES)
        begin
            idx = SINE_TABLE_ENTRIES - 1;
        end
        return wide_t'(sine_lut[int'(idx)]);
    endfunction

    // Q32 product to Q16, ties towards plus infinity.
    function automatic wide_t round_q16(input wide_t v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp_word(input wide_t v);
        if (v > S_MAX)
        begin
            return S_MAX;
        end
        if (v < S_MIN)
        begin
            return S_MIN;
        end
        return v[31:0];
    endfunction

    function automatic world_pose_t compose_world(input bone_pose_t p);
        world_pose_t w;
        wide_t       cx;
        wide_t       cy;
        wide_t       ca;
        wide_t       px;
        wide_t       py;
        wide_t       pa;
        wide_t       psx;
        wide_t       psy;
        wide_t       flip;
        wide_t       ang;
        wide_t       mx;
        wide_t       my;
        wide_t       s;
        wide_t       c;
        logic [63:0] a;
        cx  = wide_t'($signed(p.child_x));
        cy  = wide_t'($signed(p.child_y));
        ca  = wide_t'($signed(p.child_angle));
        px  = wide_t'($signed(p.parent_x));
        py  = wide_t'($signed(p.parent_y));
        pa  = wide_t'($signed(p.parent_angle));
        psx = wide_t'($signed(p.parent_scale_x));
        psy = wide_t'($signed(p.parent_scale_y));

        // A mirrored parent turns the child the other way; a zero scale kills it.
        flip = 0;
        if (psx != 0 && psy != 0)
        begin
            flip = ((psx < 0) == (psy < 0)) ? 1 : -1;
        end
        ang = pa + flip * ca;
        if (ang >= FULL_TURN)
        begin
            ang = ang - FULL_TURN;
        end
        w.world_angle = clamp_word(ang);

        w.world_scale_x = clamp_word(round_q16(wide_t'($signed(p.child_scale_x)) * psx));
        w.world_scale_y = clamp_word(round_q16(wide_t'($signed(p.child_scale_y)) * psy));

        a = (64'(p.child_alpha) * 64'(p.parent_alpha) + 64'd32768) >> 16;
        w.world_alpha = (a > 64'd65536) ? 17'd65536 : a[16:0];

        if (cx != 0 || cy != 0)
        begin
            mx = round_q16(cx * psx);
            my = round_q16(cy * psy);
            s  = lut_sine(pa);
            c  = lut_sine(pa + QUARTER_TURN);
            w.world_x = clamp_word(round_q16(mx * c - my * s) + px);
            w.world_y = clamp_word(round_q16(mx * s + my * c) + py);
        end
        else
        begin
            w.world_x = p.parent_x;
            w.world_y = p.parent_y;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic bone_pose_t pose(input int cx, input int cy, input int ca,
                                        input int csx, input int csy, input int cal,
                                        input int px, input int py, input int pa,
                                        input int psx, input int psy, input int pal);
        bone_pose_t p;
        p.child_x        = cx;
        p.child_y        = cy;
        p.child_angle    = ca;
        p.child_scale_x  = csx;
        p.child_scale_y  = csy;
        p.child_alpha    = cal[16:0];
        p.parent_x       = px;
        p.parent_y       = py;
        p.parent_angle   = pa;
        p.parent_scale_x = psx;
        p.parent_scale_y = psy;
        p.parent_alpha   = pal[16:0];
        return p;
    endfunction

    function automatic world_pose_t world(input int wx, input int wy, input int wa,
                                          input int wsx, input int wsy, input int wal);
        world_pose_t w;
        w.world_x       = wx;
        w.world_y       = wy;
        w.world_angle   = wa;
        w.world_scale_x = wsx;
        w.world_scale_y = wsy;
        w.world_alpha   = wal[16:0];
        return w;
    endfunction

    task automatic add_row(input bone_pose_t p, input logic pinned, input world_pose_t w);
        directed_row_t row;
        row.pose   = p;
        row.pinned = pinned;
        row.want   = w;
        directed_rows.push_back(row);
    endtask

    function automatic logic signed [31:0] pick_edge();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 1;
            2:       return -1;
            3:       return S_MAX;
            4:       return S_MIN;
            5:       return Q_ONE;
            default: return -Q_ONE;
        endcase
    endfunction

    // Offsets and positions: mostly within +/-128.0, some full range, some edges.
    function automatic logic signed [31:0] rand_offset();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return pick_edge();
            default: return int'($urandom_range(0, 32'h00ff_ffff)) - 32'h0080_0000;
        endcase
    endfunction

    // Scales: mostly within +/-4.0, with zeros, edges and full-range words.
    function automatic logic signed [31:0] rand_scale();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return pick_edge();
            2, 3:    return $urandom;
            default: return int'($urandom_range(0, 32'h0007_ffff)) - 32'h0004_0000;
        endcase
    endfunction

    // Angles: mostly within +/-720 degrees, some on or beside a table step.
    function automatic logic signed [31:0] rand_angle();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return pick_edge();
            2, 3:    return (int'($urandom_range(0, 2047)) - 1024) * TABLE_STEP
                            + int'($urandom_range(0, 2)) - 1;
            default: return int'($urandom_range(0, 1440 * DEG)) - 720 * DEG;
        endcase
    endfunction

    function automatic logic [16:0] rand_alpha();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 17'd65536 : 17'd0;
            1:       return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Sender pacing: bursts of random length, each preceded by a random gap
    // (often none, so long unbroken streams occur). Drop start and scramble
    // the payload during a gap so the block is seen to ignore it.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start          <= 1'b0;
                child_x        <= $urandom;
                child_y        <= $urandom;
                child_angle    <= $urandom;
                child_scale_x  <= $urandom;
                child_scale_y  <= $urandom;
                child_alpha    <= 17'($urandom);
                parent_x       <= $urandom;
                parent_y       <= $urandom;
                parent_angle   <= $urandom;
                parent_scale_x <= $urandom;
                parent_scale_y <= $urandom;
                parent_alpha   <= 17'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Present one pose, hold it until the transfer, then record what is due.
    task automatic send_pose(input bone_pose_t p, input logic pinned, input world_pose_t want);
        start          <= 1'b1;
        child_x        <= p.child_x;
        child_y        <= p.child_y;
        child_angle    <= p.child_angle;
        child_scale_x  <= p.child_scale_x;
        child_scale_y  <= p.child_scale_y;
        child_alpha    <= p.child_alpha;
        parent_x       <= p.parent_x;
        parent_y       <= p.parent_y;
        parent_angle   <= p.parent_angle;
        parent_scale_x <= p.parent_scale_x;
        parent_scale_y <= p.parent_scale_y;
        parent_alpha   <= p.parent_alpha;
        @(posedge clk);
        while (busy) @(posedge clk);
        world_due_q.push_back(pinned ? want : compose_world(p));
        items_sent++;
        if (p.child_x == 0 && p.child_y == 0)
        begin
            zero_offset_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic signed [32:0] got,
                               input logic signed [32:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      results_checked, name, got, want));
        end
    endtask

    // A result is on the ports for exactly one cycle; take it at the edge that
    // ends that cycle and compare it against the oldest pose still due.
    always @(posedge clk)
    begin
        world_pose_t want;
        if (rst_n && done)
        begin
            if (world_due_q.size() == 0)
            begin
                report_mismatch("result strobe with no transfer outstanding");
            end
            else
            begin
                want = world_due_q.pop_front();
                check_field("world_x", world_x, $signed(want.world_x));
                check_field("world_y", world_y, $signed(want.world_y));
                check_field("world_angle", world_angle, $signed(want.world_angle));
                check_field("world_scale_x", world_scale_x, $signed(want.world_scale_x));
                check_field("world_scale_y", world_scale_y, $signed(want.world_scale_y));
                check_field("world_alpha", world_alpha, want.world_alpha);
                results_checked++;
            end
        end
    end

    // Watchdog: any cycle with neither an input transfer nor a result counts
    // towards the limit; a run that stalls that long is declared dead.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] timeout: %0d cycles without a transfer, %0d results due",
                     $time, stall_cycles, world_due_q.size());
            $display("** bone_transform_compose: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        bone_pose_t p;

        // Hold every input at a known value and keep reset low from time zero.
        rst_n          <= 1'b0;
        start          <= 1'b0;
        child_x        <= '0;
        child_y        <= '0;
        child_angle    <= '0;
        child_scale_x  <= '0;
        child_scale_y  <= '0;
        child_alpha    <= '0;
        parent_x       <= '0;
        parent_y       <= '0;
        parent_angle   <= '0;
        parent_scale_x <= '0;
        parent_scale_y <= '0;
        parent_alpha   <= '0;

        fill_sine_lut();

        // Directed table. Rows with a typed-in world pose cover the cases whose
        // answer needs no arithmetic: zero child offset returns the parent
        // position, the single 360-degree fold, the sign flip from a mirrored
        // or collapsed parent, and saturation of angle, scales and opacity.
        add_row(pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b1, world(0, 0, 0, 0, 0, 0));
        add_row(pose(0, 0, 90 * DEG, Q_ONE, Q_ONE, Q_ONE,
                     123 * Q_ONE, -7 * Q_ONE, 30 * DEG, Q_ONE, Q_ONE, Q_ONE),
                1'b1, world(123 * Q_ONE, -7 * Q_ONE, 120 * DEG, Q_ONE, Q_ONE, Q_ONE));
        // Sum past a full turn folds once.
        add_row(pose(0, 0, 100 * DEG, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, 300 * DEG, Q_ONE, Q_ONE, Q_ONE),
                1'b1, world(0, 0, 40 * DEG, Q_ONE, Q_ONE, Q_ONE));
        // Exactly a full turn folds to zero.
        add_row(pose(0, 0, 180 * DEG, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, 180 * DEG, Q_ONE, Q_ONE, Q_ONE),
                1'b1, world(0, 0, 0, Q_ONE, Q_ONE, Q_ONE));
        // Far above two turns: one fold is not enough, so it saturates high.
        add_row(pose(0, 0, S_MAX, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, S_MAX, Q_ONE, Q_ONE, Q_ONE),
                1'b1, world(0, 0, S_MAX, Q_ONE, Q_ONE, Q_ONE));
        // Negative sums are left alone, and saturate low at the bottom.
        add_row(pose(0, 0, -100, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, -90 * DEG, Q_ONE, Q_ONE, Q_ONE),
                1'b1, world(0, 0, -90 * DEG - 100, Q_ONE, Q_ONE, Q_ONE));
        add_row(pose(0, 0, S_MIN, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, S_MIN, Q_ONE, Q_ONE, Q_ONE),
                1'b1, world(0, 0, S_MIN, Q_ONE, Q_ONE, Q_ONE));
        // Zero parent scale: the child angle drops out.
        add_row(pose(0, 0, 77 * DEG, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, 1000, 0, Q_ONE, Q_ONE),
                1'b1, world(0, 0, 1000, 0, Q_ONE, Q_ONE));
        add_row(pose(0, 0, 33, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, 400 * DEG, Q_ONE, 0, Q_ONE),
                1'b1, world(0, 0, 40 * DEG, Q_ONE, 0, Q_ONE));
        // Mirrored parent subtracts the child angle; doubly mirrored adds it.
        add_row(pose(0, 0, 90 * DEG, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, 10 * DEG, -Q_ONE, Q_ONE, Q_ONE),
                1'b1, world(0, 0, -80 * DEG, -Q_ONE, Q_ONE, Q_ONE));
        add_row(pose(0, 0, 100, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, 0, -Q_ONE, -Q_ONE, Q_ONE),
                1'b1, world(0, 0, 100, -Q_ONE, -Q_ONE, Q_ONE));
        // Opacity above one clamps; check the rounding tie either side.
        add_row(pose(0, 0, 0, Q_ONE, Q_ONE, 131071,
                     0, 0, 0, Q_ONE, Q_ONE, 131071),
                1'b1, world(0, 0, 0, Q_ONE, Q_ONE, 65536));
        add_row(pose(0, 0, 0, Q_ONE, Q_ONE, 1, 0, 0, 0, Q_ONE, Q_ONE, 32768),
                1'b1, world(0, 0, 0, Q_ONE, Q_ONE, 1));
        add_row(pose(0, 0, 0, Q_ONE, Q_ONE, 1, 0, 0, 0, Q_ONE, Q_ONE, 32767),
                1'b1, world(0, 0, 0, Q_ONE, Q_ONE, 0));
        // Scale products saturating in both directions.
        add_row(pose(0, 0, 0, S_MAX, S_MAX, 0, 0, 0, 0, S_MAX, S_MAX, 0),
                1'b1, world(0, 0, 0, S_MAX, S_MAX, 0));
        add_row(pose(0, 0, 12345, S_MIN, S_MIN, 0, 0, 0, 0, S_MIN, S_MAX, 0),
                1'b1, world(0, 0, -12345, S_MAX, S_MIN, 0));
        // Extreme parent position passes straight through.
        add_row(pose(0, 0, S_MIN, 3, 3, 65536,
                     S_MAX, S_MIN, 5, Q_ONE, Q_ONE, 131071),
                1'b1, world(S_MAX, S_MIN, S_MIN + 5, 3, 3, 65536));

        // Rotation rows, left to the predictor: each quadrant, the last table
        // entry, both sides of a table step and saturating positions.
        add_row(pose(Q_ONE, 0, 0, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, 0, Q_ONE, Q_ONE, Q_ONE), 1'b0, '0);
        add_row(pose(Q_ONE, 2 * Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE,
                     Q_ONE, Q_ONE, 90 * DEG, Q_ONE, Q_ONE, Q_ONE), 1'b0, '0);
        add_row(pose(-3 * Q_ONE, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, 180 * DEG, 2 * Q_ONE, Q_ONE, Q_ONE), 1'b0, '0);
        add_row(pose(Q_ONE, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, -1, Q_ONE, Q_ONE, Q_ONE), 1'b0, '0);
        add_row(pose(0, -5 * Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE,
                     10 * Q_ONE, 0, TABLE_STEP - 1, 2 * Q_ONE, -3 * Q_ONE, Q_ONE), 1'b0, '0);
        add_row(pose(7 * Q_ONE, 0, 0, Q_ONE, Q_ONE, Q_ONE,
                     0, 0, TABLE_STEP, Q_ONE, Q_ONE, Q_ONE), 1'b0, '0);
        add_row(pose(S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, 65536,
                     S_MAX, S_MAX, S_MIN, S_MAX, S_MAX, 65536), 1'b0, '0);
        add_row(pose(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 131071,
                     S_MIN, S_MIN, S_MAX, S_MIN, S_MIN, 131071), 1'b0, '0);
        add_row(pose(-1, 1, -1, -1, 1, 1, -1, 1, FULL_TURN - 1, 1, 1, 1), 1'b0, '0);

        // Hold reset, then release it before driving the first pose.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            pace();
            send_pose(directed_rows[i].pose, directed_rows[i].pinned, directed_rows[i].want);
        end

        // Random poses: mostly plausible skeleton values, with full-range words,
        // edges and zero child offsets mixed in.
        repeat (RANDOM_ITEMS)
        begin
            p.child_x        = rand_offset();
            p.child_y        = rand_offset();
            p.child_angle    = rand_angle();
            p.child_scale_x  = rand_scale();
            p.child_scale_y  = rand_scale();
            p.child_alpha    = rand_alpha();
            p.parent_x       = rand_offset();
            p.parent_y       = rand_offset();
            p.parent_angle   = rand_angle();
            p.parent_scale_x = rand_scale();
            p.parent_scale_y = rand_scale();
            p.parent_alpha   = rand_alpha();
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    p.child_x = 0;
                    p.child_y = 0;
                end
                2:       p.child_x = 0;
                3:       p.child_y = 0;
                default: ;
            endcase
            pace();
            send_pose(p, 1'b0, '0);
        end
        start <= 1'b0;

        // Drain: wait for every due result, then allow for the pipeline depth
        // so a stray extra strobe is still caught.
        while (world_due_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input transfers (%0d directed, %0d with zero child offset).",
                 items_sent, directed_rows.size(), zero_offset_items);
        $display("Checked %0d results field by field; %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("** bone_transform_compose: PASSED **");
        end
        else
        begin
            $display("** bone_transform_compose: FAILED **");
        end
        $finish;
    end

endmodule
